@@ design/ecal_pkg.sv @@
package ecal_pkg;

	// Split phases: each runs one pass through the shared multiplier
	localparam logic [1:0] PH_SEC  = 2'd0;
	localparam logic [1:0] PH_MIN  = 2'd1;
	localparam logic [1:0] PH_HOUR = 2'd2;
	localparam logic [1:0] PH_WDAY = 2'd3;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       split;
		logic [1:0] phase;
		logic       year_step;
		logic       year_end;
		logic       month_step;
	} ecal_cmd_t;

	typedef struct packed {
		logic year_fit;
		logic month_fit;
	} ecal_sts_t;

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		begin
			unique case (month)
				4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
				4'd3, 4'd5, 4'd8, 4'd10:                   d = 5'd30;
				4'd1:                                      d = leap ? 5'd29 : 5'd28;
				default:                                   d = 5'd31;
			endcase
			return d;
		end
	endfunction

endpackage

@@ design/ecal_ctrl.sv @@
module ecal_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ecal_pkg::ecal_sts_t sts,
	output ecal_pkg::ecal_cmd_t cmd,
	output logic                busy,
	output logic                done
);
	import ecal_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SPLIT = 3'd2;
	localparam logic [2:0] ST_YEAR  = 3'd3;
	localparam logic [2:0] ST_MONTH = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		cmd.phase = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					phase_d  = PH_SEC;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				if (phase_q == PH_WDAY) begin
					state_d = ST_YEAR;
				end else begin
					phase_d = phase_q + 2'd1;
					state_d = ST_MUL;
				end
			end
			ST_YEAR: begin
				if (sts.year_fit) begin
					cmd.year_end = 1'b1;
					state_d      = ST_MONTH;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			ST_MONTH: begin
				if (sts.month_fit) begin
					state_d = ST_DONE;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_SEC;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

@@ design/ecal_dp.sv @@
module ecal_dp (
	input  logic                clk,
	input  ecal_pkg::ecal_cmd_t cmd,
	output ecal_pkg::ecal_sts_t sts,
	input  logic [31:0]         epoch_seconds,
	output logic [5:0]          second_of_minute,
	output logic [5:0]          minute_of_hour,
	output logic [4:0]          hour_of_day,
	output logic [4:0]          day_of_month,
	output logic [3:0]          month_index,
	output logic [7:0]          years_since_1900,
	output logic [8:0]          day_of_year,
	output logic [2:0]          weekday
);
	import ecal_pkg::*;

	// Reciprocal constants: exact over the operand ranges used here
	localparam logic [31:0] RECIP_60 = 32'h8888_8889;  // >> 37
	localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;  // >> 36
	localparam logic [31:0] RECIP_7  = 32'd149797;     // >> 20, operand below 2^17

	logic [31:0] secs_q;
	logic [26:0] mins_q;
	logic [20:0] hours_q;
	logic [15:0] rem_q;
	logic [63:0] prod_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [2:0]  wday_q;
	logic [7:0]  year_q;
	logic [1:0]  c4_q;
	logic [6:0]  c100_q;
	logic [8:0]  c400_q;
	logic [8:0]  yday_q;
	logic [3:0]  month_q;

	logic [31:0] mul_a, mul_b;
	logic [16:0] wday_arg;
	logic [11:0] q60_lo;
	logic [11:0] q60_lo_h;
	logic [9:0]  q24_lo;
	logic [5:0]  q7_lo;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	assign wday_arg = {1'b0, rem_q} + 17'd4;

	always_comb begin
		unique case (cmd.phase)
			PH_SEC:  begin mul_a = secs_q;                mul_b = RECIP_60; end
			PH_MIN:  begin mul_a = {5'd0, mins_q};        mul_b = RECIP_60; end
			PH_HOUR: begin mul_a = {11'd0, hours_q};      mul_b = RECIP_24; end
			default: begin mul_a = {15'd0, wday_arg};     mul_b = RECIP_7;  end
		endcase
	end

	// Low bits of quotient times divisor; remainders fit below the modulus
	assign q60_lo   = {6'd0, prod_q[42:37]} * 12'd60;
	assign q60_lo_h = {6'd0, prod_q[42:37]} * 12'd60;
	assign q24_lo   = {5'd0, prod_q[40:36]} * 10'd24;
	assign q7_lo    = {3'd0, prod_q[22:20]} * 6'd7;

	assign leap = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = month_days(month_q, leap);

	assign sts.year_fit  = (rem_q < {7'd0, ylen});
	assign sts.month_fit = (month_q == 4'd11) || (rem_q < {11'd0, mlen});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			secs_q  <= epoch_seconds;
			year_q  <= 8'd70;
			c4_q    <= 2'd2;
			c100_q  <= 7'd70;
			c400_q  <= 9'd370;
			month_q <= 4'd0;
		end
		if (cmd.mul) begin
			prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
		end
		if (cmd.split) begin
			unique case (cmd.phase)
				PH_SEC: begin
					mins_q <= prod_q[63:37];
					sec_q  <= secs_q[5:0] - q60_lo[5:0];
				end
				PH_MIN: begin
					hours_q <= prod_q[57:37];
					min_q   <= mins_q[5:0] - q60_lo_h[5:0];
				end
				PH_HOUR: begin
					rem_q  <= prod_q[51:36];
					hour_q <= hours_q[4:0] - q24_lo[4:0];
				end
				default: begin
					wday_q <= wday_arg[2:0] - q7_lo[2:0];
				end
			endcase
		end
		if (cmd.year_step) begin
			rem_q  <= rem_q - {7'd0, ylen};
			year_q <= year_q + 8'd1;
			c4_q   <= c4_q + 2'd1;
			c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
			c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
		end
		if (cmd.year_end) begin
			yday_q <= rem_q[8:0];
		end
		if (cmd.month_step) begin
			rem_q   <= rem_q - {11'd0, mlen};
			month_q <= month_q + 4'd1;
		end
	end

	assign second_of_minute = sec_q;
	assign minute_of_hour   = min_q;
	assign hour_of_day      = hour_q;
	assign day_of_month     = rem_q[4:0] + 5'd1;
	assign month_index      = month_q;
	assign years_since_1900 = year_q;
	assign day_of_year      = yday_q;
	assign weekday          = wday_q;

endmodule

@@ design/epoch_seconds_to_calendar_top.sv @@
// Once a request is taken, MUL and SPLIT run for four passes through one shared 32x32
// multiplier, then the year walk steps Y years, one year per cycle, and the month walk
// steps M months before done rises; Y is the number of whole years past 1970 (0..136)
// and M the month index (0..11); Y + M is largest in December 2105, since the input
// range ends in February 2106. A new request is taken only while idle. Reset clears
// only the controller; results stay valid from done until the next request is taken.
module epoch_seconds_to_calendar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_index,
	output logic [7:0]  years_since_1900,
	output logic [8:0]  day_of_year,
	output logic [2:0]  weekday
);
	import ecal_pkg::*;

	ecal_cmd_t cmd;
	ecal_sts_t sts;

	ecal_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ecal_dp u_dp (
		.clk              (clk),
		.cmd              (cmd),
		.sts              (sts),
		.epoch_seconds    (epoch_seconds),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.day_of_month     (day_of_month),
		.month_index      (month_index),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.weekday          (weekday)
	);

endmodule

@@ design/ecal_chk.sv @@
module ecal_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] epoch_seconds,
	input logic        done,
	input logic [5:0]  second_of_minute,
	input logic [5:0]  minute_of_hour,
	input logic [4:0]  hour_of_day,
	input logic [4:0]  day_of_month,
	input logic [3:0]  month_index,
	input logic [7:0]  years_since_1900,
	input logic [8:0]  day_of_year,
	input logic [2:0]  weekday
);

	// A taken request keeps the block busy until its result
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block not free after result");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> second_of_minute < 6'd60 && minute_of_hour < 6'd60 &&
			hour_of_day < 5'd24 && weekday < 3'd7)
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> day_of_month != 5'd0 && month_index < 4'd12 &&
			years_since_1900 >= 8'd70 && years_since_1900 <= 8'd206 &&
			day_of_year < 9'd366)
		else $error("date out of range");

endmodule

bind epoch_seconds_to_calendar_top ecal_chk u_chk (.*);
